/* hdl/rgba_ss_pkg.sv */
`default_nettype none

package rgba_ss_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int PIX_W         = 32;
    localparam int SW_W          = 12;
    localparam int CFG_W         = 12;
    localparam int CFG_IDX_W     = 2;

    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [PIX_W-1:0] CONST_WORD = 32'h0000_00ff;
    localparam logic [PIX_W-1:0] MASK_B3    = 32'hff00_0000;
    localparam logic [PIX_W-1:0] MASK_B2    = 32'h00ff_0000;
    localparam logic [PIX_W-1:0] MASK_B1    = 32'h0000_ff00;
    localparam logic [PIX_W-1:0] MASK_B0    = 32'h0000_00ff;
    localparam logic [SW_W-1:0]  SW_RESET   = 12'd2048;

    typedef enum logic [2:0] {
        MODE_MAX   = 3'd0,
        MODE_MIN   = 3'd1,
        MODE_AVG   = 3'd2,
        MODE_TL    = 3'd3,
        MODE_TR    = 3'd4,
        MODE_BL    = 3'd5,
        MODE_BR    = 3'd6,
        MODE_CONST = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        CH_ALL = 3'd0,
        CH_B3  = 3'd1,
        CH_B2  = 3'd2,
        CH_B1  = 3'd3,
        CH_B0  = 3'd4
    } chsel_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_CHAN  = 2'd1,
        REG_WIDTH = 2'd2
    } reg_idx_t;

    typedef struct packed {
        mode_t             reduce_mode;
        chsel_t            channel_select;
        logic [SW_W-1:0]   source_width;
    } cfg_t;

    // one 2x2 block, queued between front and back
    typedef struct packed {
        logic [PIX_W-1:0] tl;
        logic [PIX_W-1:0] tr;
        logic [PIX_W-1:0] bl;
        logic [PIX_W-1:0] br;
        logic             row_end;
    } blk_t;

    typedef struct packed {
        logic [QCW-1:0] count;
        logic           not_empty;
    } q_stat_t;

endpackage

`default_nettype wire

/* hdl/rgba_ss_ram.sv */
`default_nettype none

module rgba_ss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/rgba_ss_front.sv */
`default_nettype none

module rgba_ss_front #(
    parameter int MAX_WIDTH = rgba_ss_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rgba_ss_pkg::PIX_W-1:0]   s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic [rgba_ss_pkg::SW_W-1:0]    source_width,
    input  wire rgba_ss_pkg::q_stat_t            q_stat,
    output logic                                 push_valid,
    output rgba_ss_pkg::blk_t                    push_blk
);

    localparam int CW = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
    localparam int AW = CW - 1;
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > rgba_ss_pkg::SW_W) ? WW : rgba_ss_pkg::SW_W;
    localparam logic [EW-1:0] MAX_EVEN = EW'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [EW-1:0] MIN_W    = EW'(2);

    logic [CW-1:0] col_reg, col_next;
    logic          odd_reg, odd_next;
    logic [rgba_ss_pkg::PIX_W-1:0] left_reg, left_next;
    logic          s1_valid_reg, s1_valid_next;
    logic [rgba_ss_pkg::PIX_W-1:0] s1_bl_reg, s1_br_reg;
    logic          s1_end_reg;

    logic [EW-1:0] sw_even, w, col_base, col, col_inc;
    logic          odd_cur, accept, rd_en, wr_even, wr_odd, at_end;
    logic [AW-1:0] bank_addr;
    logic [rgba_ss_pkg::PIX_W-1:0] even_rdata, odd_rdata;
    logic [rgba_ss_pkg::QCW:0] credit;

    always_comb begin
        sw_even = EW'({source_width[rgba_ss_pkg::SW_W-1:1], 1'b0});
        if (sw_even < MIN_W) begin
            w = MIN_W;
        end else if (sw_even > MAX_EVEN) begin
            w = MAX_EVEN;
        end else begin
            w = sw_even;
        end
    end

    assign credit   = (rgba_ss_pkg::QCW + 1)'(q_stat.count)
                    + (rgba_ss_pkg::QCW + 1)'(s1_valid_reg);
    assign s_tready = (credit < (rgba_ss_pkg::QCW + 1)'(rgba_ss_pkg::QDEPTH));
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_base = s_tuser ? '0 : EW'(col_reg);
        odd_cur  = s_tuser ? 1'b0 : odd_reg;
        col      = (col_base >= w) ? '0 : col_base;
        col_inc  = col + EW'(1);
        at_end   = (col == w - EW'(1));
        bank_addr = col[AW:1];

        wr_even = accept && !odd_cur && !col[0];
        wr_odd  = accept && !odd_cur && col[0];
        rd_en   = accept && odd_cur && col[0];

        col_next      = col_reg;
        odd_next      = odd_reg;
        left_next     = left_reg;
        s1_valid_next = rd_en;
        if (accept) begin
            if (odd_cur && !col[0]) begin
                left_next = s_tdata;
            end
            if (col_inc >= w) begin
                col_next = '0;
                odd_next = !odd_cur;
            end else begin
                col_next = col_inc[CW-1:0];
                odd_next = odd_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            odd_reg      <= 1'b0;
            left_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg      <= col_next;
            odd_reg      <= odd_next;
            left_reg     <= left_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            s1_bl_reg  <= left_reg;
            s1_br_reg  <= s_tdata;
            s1_end_reg <= at_end;
        end
    end

    // even source columns in one bank, odd in the other: one block reads both
    rgba_ss_ram #(
        .WIDTH (rgba_ss_pkg::PIX_W),
        .DEPTH (BANK_DEPTH),
        .ADDR_W(AW)
    ) u_bank_even (
        .aclk (aclk),
        .we   (wr_even),
        .waddr(bank_addr),
        .wdata(s_tdata),
        .re   (rd_en),
        .raddr(bank_addr),
        .rdata(even_rdata)
    );

    rgba_ss_ram #(
        .WIDTH (rgba_ss_pkg::PIX_W),
        .DEPTH (BANK_DEPTH),
        .ADDR_W(AW)
    ) u_bank_odd (
        .aclk (aclk),
        .we   (wr_odd),
        .waddr(bank_addr),
        .wdata(s_tdata),
        .re   (rd_en),
        .raddr(bank_addr),
        .rdata(odd_rdata)
    );

    assign push_valid       = s1_valid_reg;
    assign push_blk.tl      = even_rdata;
    assign push_blk.tr      = odd_rdata;
    assign push_blk.bl      = s1_bl_reg;
    assign push_blk.br      = s1_br_reg;
    assign push_blk.row_end = s1_end_reg;

endmodule

`default_nettype wire

/* hdl/rgba_ss_queue.sv */
`default_nettype none

module rgba_ss_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire rgba_ss_pkg::blk_t     push_blk,
    input  wire logic                  pop,
    output rgba_ss_pkg::blk_t          head_blk,
    output rgba_ss_pkg::q_stat_t       q_stat
);

    rgba_ss_pkg::blk_t entry_reg [rgba_ss_pkg::QDEPTH];

    logic [rgba_ss_pkg::QPW-1:0] wptr_reg, wptr_next;
    logic [rgba_ss_pkg::QPW-1:0] rptr_reg, rptr_next;
    logic [rgba_ss_pkg::QCW-1:0] count_reg, count_next;

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_blk;
        end
    end

    assign head_blk         = entry_reg[rptr_reg];
    assign q_stat.count     = count_reg;
    assign q_stat.not_empty = (count_reg != '0);

endmodule

`default_nettype wire

/* hdl/rgba_ss_back.sv */
`default_nettype none

module rgba_ss_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire rgba_ss_pkg::q_stat_t          q_stat,
    input  wire rgba_ss_pkg::blk_t             head_blk,
    input  wire rgba_ss_pkg::mode_t            reduce_mode,
    input  wire rgba_ss_pkg::chsel_t           channel_select,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rgba_ss_pkg::PIX_W-1:0]      m_tdata,
    output logic                               m_tlast
);

    logic                          out_valid_reg, out_valid_next;
    logic [rgba_ss_pkg::PIX_W-1:0] out_data_reg;
    logic                          out_last_reg;
    logic [rgba_ss_pkg::PIX_W-1:0] reduced, masked;

    always_comb begin
        logic [7:0] a, b, c, d, v;
        logic [9:0] sum;
        reduced = '0;
        for (int k = 0; k < 4; k++) begin
            a   = head_blk.tl[8*k +: 8];
            b   = head_blk.tr[8*k +: 8];
            c   = head_blk.bl[8*k +: 8];
            d   = head_blk.br[8*k +: 8];
            sum = 10'(a) + 10'(b) + 10'(c) + 10'(d);
            v   = sum[9:2];
            if (reduce_mode == rgba_ss_pkg::MODE_MAX) begin
                v = (a > b) ? a : b;
                v = (v > c) ? v : c;
                v = (v > d) ? v : d;
            end else if (reduce_mode == rgba_ss_pkg::MODE_MIN) begin
                v = (a < b) ? a : b;
                v = (v < c) ? v : c;
                v = (v < d) ? v : d;
            end
            reduced[8*k +: 8] = v;
        end
        unique case (reduce_mode)
            rgba_ss_pkg::MODE_MAX,
            rgba_ss_pkg::MODE_MIN,
            rgba_ss_pkg::MODE_AVG:   ;
            rgba_ss_pkg::MODE_TL:    reduced = head_blk.tl;
            rgba_ss_pkg::MODE_TR:    reduced = head_blk.tr;
            rgba_ss_pkg::MODE_BL:    reduced = head_blk.bl;
            rgba_ss_pkg::MODE_BR:    reduced = head_blk.br;
            default:                 reduced = rgba_ss_pkg::CONST_WORD;
        endcase
    end

    always_comb begin
        unique case (channel_select)
            rgba_ss_pkg::CH_B3: masked = reduced & rgba_ss_pkg::MASK_B3;
            rgba_ss_pkg::CH_B2: masked = reduced & rgba_ss_pkg::MASK_B2;
            rgba_ss_pkg::CH_B1: masked = reduced & rgba_ss_pkg::MASK_B1;
            rgba_ss_pkg::CH_B0: masked = reduced & rgba_ss_pkg::MASK_B0;
            default:            masked = reduced;
        endcase
    end

    assign pop = q_stat.not_empty && (!out_valid_reg || m_tready);

    always_comb begin
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= masked;
            out_last_reg <= head_blk.row_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* hdl/rgba_2x2_subsampler_unit.sv */
// A pixel completing a 2x2 block passes the read stage, block queue and output register.
// Throughput: one pixel per cycle if s_tready; at most one result per two pixels, odd rows.
// s_tready drops only when the 4-entry block queue plus the word being read would overflow.
// Line store: two banks of MAX_WIDTH/2 words, one write or one read port each per cycle.
// Reset (aresetn low, synchronous): counters, queue and output cleared, config to defaults;
// line store contents are not cleared.
`default_nettype none

module rgba_2x2_subsampler_unit #(
    parameter int MAX_WIDTH = rgba_ss_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [rgba_ss_pkg::PIX_W-1:0]     s_tdata,   // pixel_word
    input  wire logic                              s_tuser,   // frame_start
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [rgba_ss_pkg::PIX_W-1:0]          m_tdata,   // out_pixel
    output logic                                   m_tlast,   // row_end
    input  wire logic                              cfg_we,
    input  wire logic [rgba_ss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [rgba_ss_pkg::CFG_W-1:0]     cfg_wdata
);

    rgba_ss_pkg::cfg_t    cfg_reg, cfg_next;
    rgba_ss_pkg::q_stat_t q_stat;
    rgba_ss_pkg::blk_t    push_blk, head_blk;
    logic                 push_valid, pop;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (rgba_ss_pkg::reg_idx_t'(cfg_addr))
                rgba_ss_pkg::REG_MODE:
                    cfg_next.reduce_mode = rgba_ss_pkg::mode_t'(cfg_wdata[2:0]);
                rgba_ss_pkg::REG_CHAN:
                    cfg_next.channel_select = rgba_ss_pkg::chsel_t'(cfg_wdata[2:0]);
                rgba_ss_pkg::REG_WIDTH:
                    cfg_next.source_width = cfg_wdata[rgba_ss_pkg::SW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reduce_mode    <= rgba_ss_pkg::MODE_MAX;
            cfg_reg.channel_select <= rgba_ss_pkg::CH_ALL;
            cfg_reg.source_width   <= rgba_ss_pkg::SW_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rgba_ss_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .source_width(cfg_reg.source_width),
        .q_stat      (q_stat),
        .push_valid  (push_valid),
        .push_blk    (push_blk)
    );

    rgba_ss_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push_valid),
        .push_blk(push_blk),
        .pop     (pop),
        .head_blk(head_blk),
        .q_stat  (q_stat)
    );

    rgba_ss_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .head_blk      (head_blk),
        .reduce_mode   (cfg_reg.reduce_mode),
        .channel_select(cfg_reg.channel_select),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

endmodule

`default_nettype wire

/* hdl/rgba_ss_checker.sv */
`default_nettype none

module rgba_ss_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [rgba_ss_pkg::PIX_W-1:0]     s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [rgba_ss_pkg::PIX_W-1:0]     m_tdata,
    input  wire logic                              m_tlast,
    input  wire logic                              cfg_we,
    input  wire logic [rgba_ss_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [rgba_ss_pkg::CFG_W-1:0]     cfg_wdata
);

    logic [2:0] mode_reg, mode_next;
    logic [2:0] chan_reg, chan_next;
    logic       any_in;

    assign any_in = s_tvalid ^ s_tready ^ s_tuser ^ (^s_tdata);

    always_comb begin
        mode_next = mode_reg;
        chan_next = chan_reg;
        if (cfg_we && cfg_addr == rgba_ss_pkg::REG_MODE) begin
            mode_next = cfg_wdata[2:0];
        end
        if (cfg_we && cfg_addr == rgba_ss_pkg::REG_CHAN) begin
            chan_next = cfg_wdata[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rgba_ss_pkg::MODE_MAX;
            chan_reg <= rgba_ss_pkg::CH_ALL;
        end else begin
            mode_reg <= mode_next;
            chan_reg <= chan_next;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_const_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_reg == rgba_ss_pkg::MODE_CONST && chan_reg == rgba_ss_pkg::CH_ALL
        |-> m_tdata == rgba_ss_pkg::CONST_WORD)
        else $error("constant mode gave a different word");

    a_lane_b3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chan_reg == rgba_ss_pkg::CH_B3 |-> m_tdata[23:0] == 24'h0)
        else $error("channel select left other lanes set");

    a_lane_b0: assert property (@(posedge aclk) disable iff (!aresetn || any_in === 1'bx)
        m_tvalid && chan_reg == rgba_ss_pkg::CH_B0 |-> m_tdata[31:8] == 24'h0)
        else $error("channel select left other lanes set");

endmodule

bind rgba_2x2_subsampler_unit rgba_ss_checker u_rgba_ss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
);

`default_nettype wire
